>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/mvtgpd_pkg.sv
`default_nettype none

package mvtgpd_pkg;

   // Decoder phase: what the next complete varint means.
   typedef enum logic [1:0] {
      PH_CMD = 2'd0,
      PH_DX  = 2'd1,
      PH_DY  = 2'd2
   } phase_type;

   // Result kinds as they appear on the response channel.
   typedef enum logic [1:0] {
      KIND_MARKER    = 2'd0,
      KIND_VERTEX    = 2'd1,
      KIND_LINE_DONE = 2'd2,
      KIND_POLY_DONE = 2'd3
   } kind_type;

   // Command ids of the geometry stream.
   localparam logic [2:0] CMD_MOVE_TO    = 3'd1;
   localparam logic [2:0] CMD_LINE_TO    = 3'd2;
   localparam logic [2:0] CMD_CLOSE_PATH = 3'd7;

   // Feature geometry types.
   localparam logic [1:0] GEOM_POINT = 2'd1;
   localparam logic [1:0] GEOM_LINE  = 2'd2;
   localparam logic [1:0] GEOM_POLY  = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_ORIGIN_X   = 2'd0;
   localparam logic [1:0] CSR_ORIGIN_Y   = 2'd1;
   localparam logic [1:0] CSR_SCALE      = 2'd2;
   localparam logic [1:0] CSR_VERTEX_CAP = 2'd3;

   // Register values after reset.
   localparam logic [27:0] SCALE_RESET      = 28'd1048576;
   localparam logic [16:0] VERTEX_CAP_RESET = 17'd65536;

   // Event queue depth between front and back end; must be a power of two.
   localparam int QUEUE_DEPTH = 4;

   // Configuration register set.
   typedef struct packed {
      logic [31:0] origin_x;
      logic [31:0] origin_y;
      logic [27:0] scale;
      logic [16:0] vertex_cap;
   } cfg_type;

   // One event from the front end, with the cursor in tile units.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] cur_x;
      logic [31:0] cur_y;
      logic [16:0] count;
      logic        last;
   } evt_type;

   // Up to two events written into the queue in one cycle.
   typedef struct packed {
      logic    valid0;
      logic    valid1;
      evt_type ev0;
      evt_type ev1;
   } push_type;

endpackage

`default_nettype wire

>>> rtl/mvtgpd_front.sv
`default_nettype none

module mvtgpd_front #(
   parameter int MAX_PATH_VERTICES = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_data_byte,
   input  logic [1:0]           req_geom_type,
   input  logic                 req_last_byte,
   input  logic [16:0]          vertex_cap,
   input  logic                 q_room,
   output mvtgpd_pkg::push_type push
);

   localparam int MaxW = $clog2(MAX_PATH_VERTICES + 1);
   localparam int CmpW = (MaxW > 17) ? MaxW : 17;
   localparam logic [3:0] GroupsKept = 4'd5;
   localparam logic [3:0] LastGroup  = 4'd9;
   localparam logic [16:0] MinLineVerts = 17'd2;
   localparam logic [16:0] MinPolyVerts = 17'd3;

   // Decoder state.
   logic [34:0]           accum_ff, accum_in;
   logic [3:0]            shift_ff, shift_in;
   mvtgpd_pkg::phase_type phase_ff, phase_in;
   logic [2:0]            cmd_id_ff, cmd_id_in;
   logic [31:0]           pairs_ff, pairs_in;
   logic [31:0]           cur_x_ff, cur_x_in;
   logic [31:0]           cur_y_ff, cur_y_in;
   logic [31:0]           held_dx_ff, held_dx_in;
   logic [16:0]           pv_ff, pv_in;

   logic        accept;
   logic [5:0]  shamt;
   logic [34:0] merged;
   logic        done;
   logic        take;
   logic [31:0] param;
   logic [2:0]  word_id;
   logic [31:0] word_count;
   logic        is_dx, is_dy, is_cmd, fin;
   logic [31:0] dx_eff, dy_eff;
   logic [31:0] new_cx, new_cy;
   logic        marker;
   logic [CmpW-1:0] cap_ext;
   logic        cap_ok;
   logic        vert;
   logic [16:0] pv_inc;
   logic [31:0] pairs_dec;
   logic        path_reset;
   logic        move_done, close_done;
   logic [16:0] pv_after;
   logic        has_a, end_done;

   // Accept a request whenever the queue has room for two events.
   assign accept    = req_valid && q_room;
   assign req_stall = !q_room;

   // Merge this byte's seven payload bits into the varint; only five groups are kept.
   assign shamt  = 6'(shift_ff[2:0]) * 6'd7;
   assign merged = (shift_ff < GroupsKept) ?
                   (accum_ff | ({28'd0, req_data_byte[6:0]} << shamt)) : accum_ff;
   assign done   = !req_data_byte[7] || (shift_ff >= LastGroup);
   assign take   = done || req_last_byte;

   // Zigzag parameter and command word fields of the finished varint.
   assign param      = {1'b0, merged[31:1]} ^ {32{merged[0]}};
   assign word_id    = merged[2:0];
   assign word_count = merged[34:3];

   // Classify the finished varint by phase.
   assign is_dx  = take && (phase_ff == mvtgpd_pkg::PH_DX);
   assign is_dy  = take && (phase_ff == mvtgpd_pkg::PH_DY);
   assign is_cmd = take && (phase_ff != mvtgpd_pkg::PH_DX) && (phase_ff != mvtgpd_pkg::PH_DY);

   // A pair completes on its dy, or on a truncated end right after its dx.
   assign fin    = is_dy || (is_dx && req_last_byte);
   assign dx_eff = is_dx ? param : held_dx_ff;
   assign dy_eff = is_dy ? param : 32'd0;
   assign new_cx = cur_x_ff + dx_eff;
   assign new_cy = cur_y_ff + dy_eff;

   // Marker or path vertex, with the path capacity limit.
   assign marker  = (cmd_id_ff == mvtgpd_pkg::CMD_MOVE_TO) &&
                    (req_geom_type == mvtgpd_pkg::GEOM_POINT);
   assign cap_ext = (CmpW'(vertex_cap) < CmpW'(MAX_PATH_VERTICES)) ?
                    CmpW'(vertex_cap) : CmpW'(MAX_PATH_VERTICES);
   assign cap_ok  = CmpW'(pv_ff) < cap_ext;
   assign vert    = fin && !marker && cap_ok;
   assign pv_inc  = pv_ff + 17'd1;
   assign pairs_dec = pairs_ff - 32'd1;

   // Path completion from command words and from the end of the feature.
   assign path_reset = is_cmd && ((word_id == mvtgpd_pkg::CMD_MOVE_TO) ||
                                  (word_id == mvtgpd_pkg::CMD_CLOSE_PATH));
   assign move_done  = is_cmd && (word_id == mvtgpd_pkg::CMD_MOVE_TO) &&
                       (req_geom_type == mvtgpd_pkg::GEOM_LINE) && (pv_ff >= MinLineVerts);
   assign close_done = is_cmd && (word_id == mvtgpd_pkg::CMD_CLOSE_PATH) &&
                       (req_geom_type == mvtgpd_pkg::GEOM_POLY) && (pv_ff >= MinPolyVerts);
   assign pv_after   = path_reset ? 17'd0 : (vert ? pv_inc : pv_ff);
   assign has_a      = move_done || close_done || (fin && (marker || cap_ok));
   assign end_done   = req_last_byte && (req_geom_type == mvtgpd_pkg::GEOM_LINE) &&
                       (pv_after >= MinLineVerts);

   // Next state of the decoder.
   always_comb begin
      accum_in   = accum_ff;
      shift_in   = shift_ff;
      phase_in   = phase_ff;
      cmd_id_in  = cmd_id_ff;
      pairs_in   = pairs_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      held_dx_in = held_dx_ff;
      pv_in      = pv_ff;
      if (accept) begin
         if (!take) begin
            accum_in = merged;
            shift_in = shift_ff + 4'd1;
         end else begin
            accum_in = 35'd0;
            shift_in = 4'd0;
            case (phase_ff)
               mvtgpd_pkg::PH_DX: begin
                  held_dx_in = param;
                  phase_in   = mvtgpd_pkg::PH_DY;
               end
               mvtgpd_pkg::PH_DY: begin
               end
               default: begin
                  phase_in = mvtgpd_pkg::PH_CMD;
                  if (path_reset) begin
                     pv_in = 17'd0;
                  end
                  if (((word_id == mvtgpd_pkg::CMD_MOVE_TO) ||
                       (word_id == mvtgpd_pkg::CMD_LINE_TO)) && (word_count != 32'd0)) begin
                     cmd_id_in = word_id;
                     pairs_in  = word_count;
                     phase_in  = mvtgpd_pkg::PH_DX;
                  end
               end
            endcase
            if (fin) begin
               cur_x_in = new_cx;
               cur_y_in = new_cy;
               pairs_in = pairs_dec;
               phase_in = (pairs_dec != 32'd0) ? mvtgpd_pkg::PH_DX : mvtgpd_pkg::PH_CMD;
               pv_in    = vert ? pv_inc : pv_ff;
            end
         end
         // The end of a feature returns the decoder to its reset state.
         if (req_last_byte) begin
            accum_in   = 35'd0;
            shift_in   = 4'd0;
            phase_in   = mvtgpd_pkg::PH_CMD;
            cmd_id_in  = 3'd0;
            pairs_in   = 32'd0;
            cur_x_in   = 32'd0;
            cur_y_in   = 32'd0;
            held_dx_in = 32'd0;
            pv_in      = 17'd0;
         end
      end
   end

   // Events written to the queue: the varint's own event first, then an end-of-line event.
   always_comb begin
      mvtgpd_pkg::evt_type ev_a;
      mvtgpd_pkg::evt_type ev_b;
      ev_a.cur_x = new_cx;
      ev_a.cur_y = new_cy;
      ev_a.last  = !end_done;
      if (move_done) begin
         ev_a.kind  = mvtgpd_pkg::KIND_LINE_DONE;
         ev_a.count = pv_ff;
      end else if (close_done) begin
         ev_a.kind  = mvtgpd_pkg::KIND_POLY_DONE;
         ev_a.count = pv_ff;
      end else if (marker) begin
         ev_a.kind  = mvtgpd_pkg::KIND_MARKER;
         ev_a.count = pv_ff;
      end else begin
         ev_a.kind  = mvtgpd_pkg::KIND_VERTEX;
         ev_a.count = pv_inc;
      end
      ev_b.kind  = mvtgpd_pkg::KIND_LINE_DONE;
      ev_b.cur_x = new_cx;
      ev_b.cur_y = new_cy;
      ev_b.count = pv_after;
      ev_b.last  = 1'b1;

      push.valid0 = accept && (has_a || end_done);
      push.valid1 = accept && has_a && end_done;
      push.ev0    = has_a ? ev_a : ev_b;
      push.ev1    = ev_b;
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff   <= 35'd0;
         shift_ff   <= 4'd0;
         phase_ff   <= mvtgpd_pkg::PH_CMD;
         cmd_id_ff  <= 3'd0;
         pairs_ff   <= 32'd0;
         cur_x_ff   <= 32'd0;
         cur_y_ff   <= 32'd0;
         held_dx_ff <= 32'd0;
         pv_ff      <= 17'd0;
      end else begin
         accum_ff   <= accum_in;
         shift_ff   <= shift_in;
         phase_ff   <= phase_in;
         cmd_id_ff  <= cmd_id_in;
         pairs_ff   <= pairs_in;
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         held_dx_ff <= held_dx_in;
         pv_ff      <= pv_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/mvtgpd_queue.sv
`default_nettype none

module mvtgpd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  mvtgpd_pkg::push_type push,
   output logic                 q_room,
   input  logic                 q_pop,
   output logic                 q_not_empty,
   output mvtgpd_pkg::evt_type  q_head
);

   localparam int Depth = mvtgpd_pkg::QUEUE_DEPTH;
   localparam int PtrW  = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);

   mvtgpd_pkg::evt_type entries [Depth];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [PtrW-1:0] wr_ptr_next;

   // Room means two free entries, enough for the most events one request makes.
   assign q_room      = count_ff <= CntW'(Depth - 2);
   assign q_not_empty = count_ff != '0;
   assign q_head      = entries[rd_ptr_ff];
   assign wr_ptr_next = wr_ptr_ff + PtrW'(1);

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrW'(push.valid0) + PtrW'(push.valid1);
      rd_ptr_in = rd_ptr_ff + PtrW'(q_pop);
      count_in  = count_ff + CntW'(push.valid0) + CntW'(push.valid1) - CntW'(q_pop);
   end

   // Event storage, written at the tail and the entry after it.
   always_ff @(posedge clock) begin
      if (push.valid0) begin
         entries[wr_ptr_ff] <= push.ev0;
      end
      if (push.valid1) begin
         entries[wr_ptr_next] <= push.ev1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/mvtgpd_back.sv
`default_nettype none

module mvtgpd_back (
   input  logic                clock,
   input  logic                reset,
   input  mvtgpd_pkg::cfg_type cfg,
   input  logic                q_not_empty,
   input  mvtgpd_pkg::evt_type q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_event_kind,
   output logic signed [15:0]  rsp_pos_x,
   output logic signed [15:0]  rsp_pos_y,
   output logic [16:0]         rsp_vertex_count,
   output logic                rsp_last_of_run
);

   // Divides by 2^24 toward zero and clamps to 16 bits.
   function automatic logic signed [15:0] clamp_pos(input logic signed [61:0] sum);
      logic signed [37:0] q_floor;
      logic signed [37:0] q;
      logic               round_up;
      q_floor  = sum[61:24];
      round_up = sum[61] && (sum[23:0] != 24'd0);
      q        = q_floor + 38'(round_up);
      if (q > 38'sd32767) begin
         clamp_pos = 16'sh7fff;
      end else if (q < -38'sd32768) begin
         clamp_pos = 16'sh8000;
      end else begin
         clamp_pos = q[15:0];
      end
   endfunction

   logic enable;

   // Stage 1: cursor times scale.
   logic                 v1_ff, v1_in;
   mvtgpd_pkg::kind_type kind1_ff, kind1_in;
   logic [16:0]          cnt1_ff, cnt1_in;
   logic                 last1_ff, last1_in;
   logic signed [59:0]   px1_ff, px1_in;
   logic signed [59:0]   py1_ff, py1_in;
   logic signed [60:0]   prod_x, prod_y;

   // Stage 2: origin added.
   logic                 v2_ff, v2_in;
   mvtgpd_pkg::kind_type kind2_ff, kind2_in;
   logic [16:0]          cnt2_ff, cnt2_in;
   logic                 last2_ff, last2_in;
   logic signed [61:0]   sx2_ff, sx2_in;
   logic signed [61:0]   sy2_ff, sy2_in;

   // Stage 3: output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   mvtgpd_pkg::kind_type rsp_kind_ff, rsp_kind_in;
   logic signed [15:0]   rsp_x_ff, rsp_x_in;
   logic signed [15:0]   rsp_y_ff, rsp_y_in;
   logic [16:0]          rsp_cnt_ff, rsp_cnt_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 is_done_kind;

   // The whole pipeline moves unless a held result is being stalled.
   assign enable = !rsp_valid_ff || !rsp_stall;
   assign q_pop  = enable && q_not_empty;

   // Stage 1 inputs.
   assign prod_x   = $signed(q_head.cur_x) * $signed({1'b0, cfg.scale});
   assign prod_y   = $signed(q_head.cur_y) * $signed({1'b0, cfg.scale});
   assign v1_in    = q_pop;
   assign kind1_in = q_head.kind;
   assign cnt1_in  = q_head.count;
   assign last1_in = q_head.last;
   assign px1_in   = prod_x[59:0];
   assign py1_in   = prod_y[59:0];

   // Stage 2 inputs: origin is Q24.8, moved up to the Q.24 product scale.
   assign v2_in    = v1_ff;
   assign kind2_in = kind1_ff;
   assign cnt2_in  = cnt1_ff;
   assign last2_in = last1_ff;
   assign sx2_in   = {{14{cfg.origin_x[31]}}, cfg.origin_x, 16'd0} + {{2{px1_ff[59]}}, px1_ff};
   assign sy2_in   = {{14{cfg.origin_y[31]}}, cfg.origin_y, 16'd0} + {{2{py1_ff[59]}}, py1_ff};

   // Stage 3 inputs: completion events carry no position.
   assign is_done_kind = (kind2_ff == mvtgpd_pkg::KIND_LINE_DONE) ||
                         (kind2_ff == mvtgpd_pkg::KIND_POLY_DONE);
   assign rsp_valid_in = v2_ff;
   assign rsp_kind_in  = kind2_ff;
   assign rsp_cnt_in   = cnt2_ff;
   assign rsp_last_in  = last2_ff;
   assign rsp_x_in     = is_done_kind ? 16'sd0 : clamp_pos(sx2_ff);
   assign rsp_y_in     = is_done_kind ? 16'sd0 : clamp_pos(sy2_ff);

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (enable) begin
         kind1_ff    <= kind1_in;
         cnt1_ff     <= cnt1_in;
         last1_ff    <= last1_in;
         px1_ff      <= px1_in;
         py1_ff      <= py1_in;
         kind2_ff    <= kind2_in;
         cnt2_ff     <= cnt2_in;
         last2_ff    <= last2_in;
         sx2_ff      <= sx2_in;
         sy2_ff      <= sy2_in;
         rsp_kind_ff <= rsp_kind_in;
         rsp_x_ff    <= rsp_x_in;
         rsp_y_ff    <= rsp_y_in;
         rsp_cnt_ff  <= rsp_cnt_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_pos_x        = rsp_x_ff;
   assign rsp_pos_y        = rsp_y_ff;
   assign rsp_vertex_count = rsp_cnt_ff;
   assign rsp_last_of_run  = rsp_last_ff;

endmodule

`default_nettype wire

>>> rtl/mvt_geometry_point_decoder.sv
// A result reaches rsp through the event queue, the scale stage, the origin stage and the
// output register; a request that yields two results writes both into the queue at once.
// Throughput: one request per cycle while the queue has room; the back end's multiply, add
// and clamp stages drain one result per cycle unless rsp_stall holds the output register.
// Reset: synchronous, active high; clears decoder state, event queue and output valid,
// and loads origin 0, scale 0x100000 and vertex cap 65536.
`default_nettype none

module mvt_geometry_point_decoder #(
   parameter int MAX_PATH_VERTICES = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic [1:0]         req_geom_type,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_event_kind,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic [16:0]        rsp_vertex_count,
   output logic               rsp_last_of_run,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   mvtgpd_pkg::cfg_type  cfg_ff, cfg_in;
   mvtgpd_pkg::push_type push;
   mvtgpd_pkg::evt_type  q_head;
   logic                 q_room;
   logic                 q_pop;
   logic                 q_not_empty;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            mvtgpd_pkg::CSR_ORIGIN_X:   cfg_in.origin_x   = csr_wdata;
            mvtgpd_pkg::CSR_ORIGIN_Y:   cfg_in.origin_y   = csr_wdata;
            mvtgpd_pkg::CSR_SCALE:      cfg_in.scale      = csr_wdata[27:0];
            mvtgpd_pkg::CSR_VERTEX_CAP: cfg_in.vertex_cap = csr_wdata[16:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x   <= 32'd0;
         cfg_ff.origin_y   <= 32'd0;
         cfg_ff.scale      <= mvtgpd_pkg::SCALE_RESET;
         cfg_ff.vertex_cap <= mvtgpd_pkg::VERTEX_CAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: varint decode, command handling, cursor and path count.
   mvtgpd_front #(
      .MAX_PATH_VERTICES (MAX_PATH_VERTICES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_geom_type (req_geom_type),
      .req_last_byte (req_last_byte),
      .vertex_cap    (cfg_ff.vertex_cap),
      .q_room        (q_room),
      .push          (push)
   );

   // Event queue between the two ends.
   mvtgpd_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .q_room      (q_room),
      .q_pop       (q_pop),
      .q_not_empty (q_not_empty),
      .q_head      (q_head)
   );

   // Back end: frame position pipeline and output register.
   mvtgpd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_not_empty      (q_not_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_vertex_count (rsp_vertex_count),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

`default_nettype wire

>>> rtl/mvtgpd_checker.sv
`default_nettype none
`include "assert_macros.svh"

module mvtgpd_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [1:0]         rsp_event_kind,
   input wire logic signed [15:0] rsp_pos_x,
   input wire logic signed [15:0] rsp_pos_y,
   input wire logic [16:0]        rsp_vertex_count,
   input wire logic               rsp_last_of_run
);

   // A stalled result stays and keeps its payload.
   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_kind) && $stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_vertex_count) && $stable(rsp_last_of_run), "stalled result changed")

   // Completion events carry no position.
   `CHK_ASSERT(a_done_no_pos, clock, reset, rsp_valid && (rsp_event_kind == 2'(mvtgpd_pkg::KIND_LINE_DONE) || rsp_event_kind == 2'(mvtgpd_pkg::KIND_POLY_DONE)) |-> rsp_pos_x == 16'sd0 && rsp_pos_y == 16'sd0, "completion event with a position")

   // A completed polygon holds at least three vertices.
   `CHK_ASSERT(a_poly_count, clock, reset, rsp_valid && rsp_event_kind == 2'(mvtgpd_pkg::KIND_POLY_DONE) |-> rsp_vertex_count >= 17'd3, "polygon completed with too few vertices")

   // A vertex event always counts itself in the path.
   `CHK_ASSERT(a_vertex_count, clock, reset, rsp_valid && rsp_event_kind == 2'(mvtgpd_pkg::KIND_VERTEX) |-> rsp_vertex_count != 17'd0, "vertex event with an empty path")

   // No result is shown right after reset.
   `CHK_ASSERT_ALWAYS(a_reset_clear, clock, $past(reset) |-> !rsp_valid, "result valid after reset")

endmodule

bind mvt_geometry_point_decoder mvtgpd_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_event_kind   (rsp_event_kind),
   .rsp_pos_x        (rsp_pos_x),
   .rsp_pos_y        (rsp_pos_y),
   .rsp_vertex_count (rsp_vertex_count),
   .rsp_last_of_run  (rsp_last_of_run)
);

`default_nettype wire

>>> verif/tb_mvt_geometry_point_decoder.sv
`timescale 1ns / 1ps

module tb_mvt_geometry_point_decoder;
   import mvtgpd_pkg::*;

   localparam int PATH_LIMIT   = 65536;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_BYTES = 1800;
   localparam int PRINT_LIMIT  = 100;
   localparam logic [1:0] GEOM_UNKNOWN = 2'd0;

   // One frame event as it should appear on the result channel.
   typedef struct packed {
      kind_type    kind;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [16:0] count;
      logic        last;
   } frame_event_t;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic [1:0]  req_geom_type;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_event_kind;
   logic [15:0] rsp_pos_x;
   logic [15:0] rsp_pos_y;
   logic [16:0] rsp_vertex_count;
   logic        rsp_last_of_run;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   mvt_geometry_point_decoder DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_geom_type    (req_geom_type),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_vertex_count (rsp_vertex_count),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Shadow copy of the registers.
   logic [31:0] org_x;
   logic [31:0] org_y;
   logic [27:0] scale_q;
   logic [16:0] cap_q;

   // Shadow copy of the decoder state.
   logic [34:0] acc_q;
   logic [3:0]  shift_q;
   phase_type   phase_q;
   logic [2:0]  cmd_q;
   logic [31:0] pairs_q;
   logic [31:0] cur_x;
   logic [31:0] cur_y;
   logic [31:0] held_dx;
   logic [16:0] path_q;

   frame_event_t expected_events[$];
   frame_event_t byte_events[$];
   logic [7:0]   blob[$];
   int           errors;
   int           cycles;
   int           bytes_sent;
   bit           quiet_req;
   bit           quiet_rsp;

   // Clock with a 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run watchdog.
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("mvt_geometry_point_decoder: mismatch");
         $finish;
      end
   end

   function automatic logic [31:0] unzigzag(logic [31:0] n);
      return (n >> 1) ^ {32{n[0]}};
   endfunction

   function automatic logic [31:0] zigzag(logic [31:0] d);
      return (d << 1) ^ {32{d[31]}};
   endfunction

   // Frame coordinate: origin plus cursor times scale, truncated toward zero and clamped.
   function automatic logic [15:0] frame_coord(logic [31:0] origin, logic [31:0] cur);
      longint acc;
      longint q;
      acc = longint'($signed(origin)) * 65536 + longint'($signed(cur)) * longint'(scale_q);
      q = acc / longint'(16777216);
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   function automatic logic [16:0] active_cap();
      return (cap_q < 17'(PATH_LIMIT)) ? cap_q : 17'(PATH_LIMIT);
   endfunction

   task automatic clear_decoder();
      acc_q   = '0;
      shift_q = '0;
      phase_q = PH_CMD;
      cmd_q   = '0;
      pairs_q = '0;
      cur_x   = '0;
      cur_y   = '0;
      held_dx = '0;
      path_q  = '0;
   endtask

   task automatic add_event(kind_type k, logic [15:0] x, logic [15:0] y, logic [16:0] n);
      frame_event_t e;
      e.kind  = k;
      e.pos_x = x;
      e.pos_y = y;
      e.count = n;
      e.last  = 1'b0;
      byte_events.push_back(e);
   endtask

   // A complete (dx, dy) pair moves the cursor and places a marker or a vertex.
   task automatic finish_pair(logic [31:0] dy, logic [1:0] g);
      cur_x = cur_x + held_dx;
      cur_y = cur_y + dy;
      if (cmd_q == CMD_MOVE_TO && g == GEOM_POINT) begin
         add_event(KIND_MARKER, frame_coord(org_x, cur_x), frame_coord(org_y, cur_y), path_q);
      end else if (path_q < active_cap()) begin
         path_q = path_q + 1;
         add_event(KIND_VERTEX, frame_coord(org_x, cur_x), frame_coord(org_y, cur_y), path_q);
      end
      pairs_q = pairs_q - 1;
      phase_q = (pairs_q != 0) ? PH_DX : PH_CMD;
   endtask

   // Works out the frame events that one accepted request causes.
   task automatic predict_request(logic [7:0] b, logic [1:0] g, logic l);
      logic [34:0] value;
      logic [2:0]  id;
      logic [31:0] cnt;
      bit          done;
      byte_events.delete();
      if (phase_q != PH_DX && phase_q != PH_DY) phase_q = PH_CMD;
      if (shift_q < 5) acc_q = acc_q | (35'(b[6:0]) << (7 * shift_q));
      done = !b[7] || shift_q >= 9;
      if (!done && !l) begin
         shift_q = shift_q + 1;
      end else begin
         value   = acc_q;
         acc_q   = '0;
         shift_q = '0;
         case (phase_q)
            PH_DX: begin
               held_dx = unzigzag(value[31:0]);
               phase_q = PH_DY;
            end
            PH_DY: finish_pair(unzigzag(value[31:0]), g);
            default: begin
               id  = value[2:0];
               cnt = value[34:3];
               phase_q = PH_CMD;
               if (id == CMD_MOVE_TO) begin
                  if (g == GEOM_LINE && path_q >= 2) add_event(KIND_LINE_DONE, '0, '0, path_q);
                  path_q = '0;
               end else if (id == CMD_CLOSE_PATH) begin
                  if (g == GEOM_POLY && path_q >= 3) add_event(KIND_POLY_DONE, '0, '0, path_q);
                  path_q = '0;
               end
               if ((id == CMD_MOVE_TO || id == CMD_LINE_TO) && cnt != 0) begin
                  cmd_q   = id;
                  pairs_q = cnt;
                  phase_q = PH_DX;
               end
            end
         endcase
      end
      // The end of a feature flushes a half pair and an open line, then resets.
      if (l) begin
         if (phase_q == PH_DY) finish_pair('0, g);
         if (g == GEOM_LINE && path_q >= 2) add_event(KIND_LINE_DONE, '0, '0, path_q);
         clear_decoder();
      end
      foreach (byte_events[i]) begin
         frame_event_t e;
         e = byte_events[i];
         e.last = (i == byte_events.size() - 1);
         expected_events.push_back(e);
      end
   endtask

   // Sends one request after a random gap and predicts it once accepted.
   task automatic send_request(logic [7:0] b, logic [1:0] g, logic l);
      int gap;
      gap = quiet_req ? 0 : $urandom_range(0, 17);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_geom_type <= g;
      req_last_byte <= l;
      do @(posedge clock); while (req_stall);
      predict_request(b, g, l);
      bytes_sent++;
   endtask

   // Sends the built geometry blob as one feature, the final byte flagged as last.
   task automatic send_blob(logic [1:0] g, bit mixed);
      foreach (blob[i]) begin
         send_request(blob[i], mixed ? 2'($urandom_range(0, 3)) : g, i == blob.size() - 1);
      end
      blob.delete();
   endtask

   // LEB128 encoding, with optional redundant zero groups.
   task automatic push_varint(logic [34:0] v, int pad);
      logic [34:0] rest;
      logic [6:0]  low;
      int          extra;
      bit          more;
      rest  = v;
      extra = pad;
      more  = 1'b1;
      while (more) begin
         low  = rest[6:0];
         rest = rest >> 7;
         more = (rest != 0) || (extra != 0);
         blob.push_back({more, low});
         if (rest == 0 && extra != 0 && more) extra--;
      end
   endtask

   task automatic push_cmd(logic [2:0] id, logic [31:0] cnt, int pad);
      push_varint({cnt, id}, pad);
   endtask

   task automatic push_pair(logic [31:0] dx, logic [31:0] dy, int pad);
      push_varint({3'b0, zigzag(dx)}, pad);
      push_varint({3'b0, zigzag(dy)}, 0);
   endtask

   function automatic int rand_pad();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10) : 0;
   endfunction

   function automatic logic [31:0] rand_delta();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return $urandom_range(0, 128) - 64;
         6, 7:             return $urandom_range(0, 10000) - 5000;
         8:                return $urandom();
         default: begin
            case ($urandom_range(0, 3))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'h0;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   function automatic logic [31:0] rand_origin();
      case ($urandom_range(0, 5))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return $urandom();
         default: return $urandom_range(0, 102400) - 51200;
      endcase
   endfunction

   // Lets the block go quiet: all results in and the pipeline drained.
   task automatic wait_idle();
      @(negedge clock) req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_ORIGIN_X:   org_x   = data;
         CSR_ORIGIN_Y:   org_y   = data;
         CSR_SCALE:      scale_q = data[27:0];
         CSR_VERTEX_CAP: cap_q   = data[16:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [31:0] ox, logic [31:0] oy, logic [31:0] sc, logic [31:0] cap);
      wait_idle();
      write_csr(CSR_ORIGIN_X, ox);
      write_csr(CSR_ORIGIN_Y, oy);
      write_csr(CSR_SCALE, sc);
      write_csr(CSR_VERTEX_CAP, cap);
   endtask

   // Point features give markers; a LineTo there still gives a vertex.
   task automatic test_point_markers();
      push_cmd(CMD_MOVE_TO, 3, 0);
      push_pair(32'h0, 32'h0, 0);
      push_pair(32'h7FFF_FFFF, 32'h8000_0000, 0);
      push_pair(32'h1, 32'hFFFF_FFFF, 0);
      push_cmd(CMD_LINE_TO, 1, 0);
      push_pair(32'h2, 32'h3, 0);
      send_blob(GEOM_POINT, 1'b0);
   endtask

   // A MoveTo closes an open line, and so does the end of the feature.
   task automatic test_line_paths();
      push_cmd(CMD_MOVE_TO, 1, 0);
      push_pair(32'd5, 32'd5, 0);
      push_cmd(CMD_LINE_TO, 2, 0);
      push_pair(32'd10, 32'd0, 0);
      push_pair(32'd0, 32'd10, 0);
      push_cmd(CMD_MOVE_TO, 1, 0);
      push_pair(-32'sd3, -32'sd3, 0);
      push_cmd(CMD_LINE_TO, 1, 0);
      push_pair(32'd1, 32'd1, 0);
      send_blob(GEOM_LINE, 1'b0);
      // Unknown geometry still builds paths but never completes them.
      push_cmd(CMD_MOVE_TO, 1, 0);
      push_pair(32'd4, 32'd4, 0);
      push_cmd(CMD_LINE_TO, 1, 0);
      push_pair(32'd1, 32'd1, 0);
      send_blob(GEOM_UNKNOWN, 1'b0);
   endtask

   // ClosePath completes a ring only with three or more vertices.
   task automatic test_polygon_rings();
      push_cmd(CMD_MOVE_TO, 1, 0);
      push_pair(32'd0, 32'd0, 0);
      push_cmd(CMD_LINE_TO, 2, 0);
      push_pair(32'd8, 32'd0, 0);
      push_pair(32'd0, 32'd8, 0);
      push_cmd(CMD_CLOSE_PATH, 1, 0);
      push_cmd(CMD_CLOSE_PATH, 1, 0);
      push_cmd(CMD_MOVE_TO, 1, 0);
      push_pair(32'd1, 32'd1, 0);
      push_cmd(CMD_LINE_TO, 1, 0);
      push_pair(32'd2, 32'd2, 0);
      push_cmd(CMD_CLOSE_PATH, 1, 0);
      send_blob(GEOM_POLY, 1'b0);
   endtask

   // Unused ids and zero counts take no parameters.
   task automatic test_ignored_commands();
      for (int id = 0; id < 8; id++) begin
         if (id != CMD_MOVE_TO && id != CMD_LINE_TO && id != CMD_CLOSE_PATH)
            push_cmd(3'(id), id + 1, 0);
      end
      push_cmd(CMD_MOVE_TO, 0, 0);
      push_cmd(CMD_LINE_TO, 0, 0);
      push_cmd(CMD_MOVE_TO, 1, 0);
      push_pair(32'd7, 32'd7, 0);
      send_blob(GEOM_LINE, 1'b0);
   endtask

   // A varint stops at its tenth byte even with the continuation bit set.
   task automatic test_long_varint();
      push_cmd(CMD_MOVE_TO, 1, 11);
      push_pair(32'd1, 32'd1, 0);
      repeat (11) blob.push_back(8'hFF);
      blob.push_back(8'h7F);
      send_blob(GEOM_POLY, 1'b0);
   endtask

   // Features cut inside a varint or between dx and dy.
   task automatic test_truncated_end();
      push_cmd(CMD_MOVE_TO, 1, 0);
      push_pair(32'd3, 32'd200, 0);
      void'(blob.pop_back());
      send_blob(GEOM_LINE, 1'b0);
      // The dy is missing and two announced pairs never arrive.
      push_cmd(CMD_MOVE_TO, 1, 0);
      push_pair(32'd2, 32'd2, 0);
      push_cmd(CMD_LINE_TO, 3, 0);
      push_varint({3'b0, zigzag(32'd5)}, 0);
      send_blob(GEOM_LINE, 1'b0);
   endtask

   // Vertices past the cap are dropped but still move the cursor.
   task automatic test_capacity();
      set_config(32'h0, 32'h0, SCALE_RESET, 32'd2);
      push_cmd(CMD_MOVE_TO, 1, 0);
      push_pair(32'd1, 32'd1, 0);
      push_cmd(CMD_LINE_TO, 4, 0);
      repeat (4) push_pair(32'd16, 32'd16, 0);
      push_cmd(CMD_MOVE_TO, 1, 0);
      push_pair(32'd16, 32'd16, 0);
      send_blob(GEOM_LINE, 1'b0);
      set_config(32'h0, 32'h0, SCALE_RESET, 32'd0);
      push_cmd(CMD_MOVE_TO, 1, 0);
      push_pair(32'd1, 32'd1, 0);
      push_cmd(CMD_LINE_TO, 2, 0);
      push_pair(32'd1, 32'd0, 0);
      push_pair(32'd0, 32'd1, 0);
      push_cmd(CMD_CLOSE_PATH, 1, 0);
      send_blob(GEOM_POLY, 1'b0);
   endtask

   // Origin and scale at their extremes, with clamping on both sides.
   task automatic test_origin_scale();
      set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h0FFF_FFFF, VERTEX_CAP_RESET);
      push_cmd(CMD_MOVE_TO, 2, 0);
      push_pair(32'd0, 32'd0, 0);
      push_pair(32'd100, -32'sd100, 0);
      send_blob(GEOM_POINT, 1'b0);
      set_config(32'd2560, -32'sd1280, 32'h0, VERTEX_CAP_RESET);
      push_cmd(CMD_MOVE_TO, 1, 0);
      push_pair(32'd50, 32'd50, 0);
      send_blob(GEOM_POINT, 1'b0);
      set_config(-32'sd76800, 32'd76800, 32'h0100_0000, VERTEX_CAP_RESET);
      push_cmd(CMD_MOVE_TO, 1, 0);
      push_pair(32'd20, -32'sd20, 0);
      push_cmd(CMD_LINE_TO, 1, 0);
      push_pair(-32'sd40000, 32'd40000, 0);
      send_blob(GEOM_LINE, 1'b0);
   endtask

   // Random features: mostly well-formed paths, some noise and cut-off blobs.
   task automatic test_random_features();
      int         start;
      int         nfeat;
      int         n;
      logic [1:0] g;
      logic [31:0] sc;
      logic [31:0] cap;
      start = bytes_sent;
      nfeat = 0;
      while (bytes_sent - start < RANDOM_BYTES) begin
         if (nfeat % 12 == 0) begin
            case ($urandom_range(0, 4))
               0:       sc = 32'h0;
               1:       sc = 32'h0FFF_FFFF;
               2:       sc = $urandom();
               default: sc = $urandom_range(32'h1_0000, 32'h40_0000);
            endcase
            case ($urandom_range(0, 4))
               0:       cap = 32'd0;
               1:       cap = VERTEX_CAP_RESET;
               2:       cap = $urandom_range(0, PATH_LIMIT);
               default: cap = $urandom_range(1, 6);
            endcase
            set_config(rand_origin(), rand_origin(), sc, cap);
            quiet_req = ($urandom_range(0, 3) == 0);
            quiet_rsp = ($urandom_range(0, 3) == 0);
         end
         nfeat++;
         g = $urandom_range(0, 3);
         if (g != GEOM_UNKNOWN && $urandom_range(0, 9) < 7) begin
            case (g)
               GEOM_POINT: begin
                  n = $urandom_range(1, 4);
                  push_cmd(CMD_MOVE_TO, n, rand_pad());
                  repeat (n) push_pair(rand_delta(), rand_delta(), rand_pad());
               end
               default: begin
                  repeat ($urandom_range(1, 3)) begin
                     push_cmd(CMD_MOVE_TO, 1, rand_pad());
                     push_pair(rand_delta(), rand_delta(), rand_pad());
                     n = $urandom_range(1, 5);
                     push_cmd(CMD_LINE_TO, n, rand_pad());
                     repeat (n) push_pair(rand_delta(), rand_delta(), rand_pad());
                     if (g == GEOM_POLY) push_cmd(CMD_CLOSE_PATH, 1, rand_pad());
                  end
               end
            endcase
         end else begin
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 7))
                  0: begin
                     n = $urandom_range(0, 3);
                     push_cmd(CMD_MOVE_TO, n, rand_pad());
                     repeat (n) push_pair(rand_delta(), rand_delta(), rand_pad());
                  end
                  1: begin
                     n = $urandom_range(0, 3);
                     push_cmd(CMD_LINE_TO, n, rand_pad());
                     repeat (n) push_pair(rand_delta(), rand_delta(), rand_pad());
                  end
                  2: push_cmd(CMD_CLOSE_PATH, $urandom_range(0, 3), rand_pad());
                  3: push_cmd($urandom_range(0, 7), $urandom(), rand_pad());
                  4: repeat ($urandom_range(1, 4)) blob.push_back($urandom_range(0, 255));
                  5: push_varint({$urandom(), 3'($urandom_range(0, 7))}, rand_pad());
                  6: begin
                     push_cmd(CMD_MOVE_TO, $urandom(), rand_pad());
                     push_pair(rand_delta(), rand_delta(), rand_pad());
                  end
                  default: begin
                     push_cmd(CMD_LINE_TO, 1, rand_pad());
                     push_pair(rand_delta(), rand_delta(), rand_pad());
                  end
               endcase
            end
         end
         // Some blobs end early, inside a varint or a pair.
         if ($urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, blob.size());
            while (blob.size() > n) void'(blob.pop_back());
         end
         send_blob(g, $urandom_range(0, 19) == 0);
      end
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (errors < PRINT_LIMIT)
         $display("ERROR %s: got %0h, expected %0h (cycle %0d)", what, got, want, cycles);
      errors++;
   endtask

   task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // Result side: random stall before each result.
   initial begin : rsp_stall_gen
      int gap;
      rsp_stall = 1'b0;
      forever begin
         gap = quiet_rsp ? 0 : $urandom_range(0, 17);
         if (gap > 0) begin
            @(negedge clock) rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Each accepted result is compared with the oldest expected event.
   always @(posedge clock) begin : check_results
      frame_event_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            report_mismatch("result with no request behind it", {30'b0, rsp_event_kind}, '0);
         end else begin
            want = expected_events.pop_front();
            check_field("event_kind", {30'b0, rsp_event_kind}, {30'b0, want.kind});
            check_field("pos_x", {16'b0, rsp_pos_x}, {16'b0, want.pos_x});
            check_field("pos_y", {16'b0, rsp_pos_y}, {16'b0, want.pos_y});
            check_field("vertex_count", {15'b0, rsp_vertex_count}, {15'b0, want.count});
            check_field("last_of_run", {31'b0, rsp_last_of_run}, {31'b0, want.last});
         end
      end
   end

   // Main sequence.
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = '0;
      req_geom_type = GEOM_UNKNOWN;
      req_last_byte = 1'b0;
      csr_we        = 1'b0;
      csr_index     = CSR_ORIGIN_X;
      csr_wdata     = '0;
      errors        = 0;
      bytes_sent    = 0;
      quiet_req     = 1'b0;
      quiet_rsp     = 1'b0;
      org_x         = '0;
      org_y         = '0;
      scale_q       = SCALE_RESET;
      cap_q         = VERTEX_CAP_RESET;
      clear_decoder();
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_point_markers();
      test_line_paths();
      test_polygon_rings();
      test_ignored_commands();
      test_long_varint();
      test_truncated_end();
      test_capacity();
      test_origin_scale();
      test_random_features();

      wait_idle();
      if (errors == 0) begin
         $display("mvt_geometry_point_decoder: match");
      end else begin
         $display("mvt_geometry_point_decoder: mismatch");
      end
      $finish;
   end

endmodule
